FILE: sv/pgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgs_pkg
// shared types and constants of the gauss-seidel poisson relaxation block
// ----------------------------------------------------------------------------
package pgs_pkg;

    localparam int GRID_SIDE_DEF = 128;
    localparam int DATA_W        = 32;
    localparam int ISZ_W         = 7;
    localparam int SWEEP_W       = 8;
    localparam int IDX_W         = 7;
    localparam int CFG_IDX_W     = 2;

    localparam logic [ISZ_W-1:0]   ISZ_RST   = 7'd99;
    localparam logic [SWEEP_W-1:0] SWEEP_RST = 8'd50;
    localparam logic [DATA_W-1:0]  SCALE_RST = 32'h0001_0000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERIOR = 2'd0,
        CFG_SWEEPS   = 2'd1,
        CFG_SCALE    = 2'd2,
        CFG_NONE     = 2'd3
    } t_cfg_idx;

endpackage

FILE: sv/pgs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgs_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/poisson_gauss_seidel_relaxation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poisson_gauss_seidel_relaxation
// in-place 5-point gauss-seidel relaxation of a square potential grid
// ----------------------------------------------------------------------------
// usage
//   input stream: tuser carries the op (load, run, read, clear), tdata the
//   row, column and source value. output stream: one beat per input beat,
//   tdata the potential (read op, else zero), tuser the sticky saturation flag.
//   config port: write enable, index, data; write only while the block is idle.
// sequence / throughput
//   load: result pushed in the accept cycle, one item per cycle while the output queue has room
//   read: the accept cycle addresses the potential ram, the result is pushed from S_RD
//   run : per cell the states S_UP, S_DN, S_RT, S_WAIT, S_CALC give three potential
//         ram reads on the single read port, a capture state for the last read
//         and the multiply, and a write
//   clear: all GRID_SIDE^2 ram words, one ram word zeroed per cycle
// reset
//   the potential ram is swept to zero after reset (all GRID_SIDE^2 words, 16384
//   at the default size); no input beat is accepted during that pass
// stall
//   results go into a two-beat output queue; input is taken while the block
//   is idle and the queue has room, so one result may wait on the receiver
//   while the next item is already accepted
// ----------------------------------------------------------------------------
module poisson_gauss_seidel_relaxation #(
    parameter int GRID_SIDE = pgs_pkg::GRID_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // row[6:0], col[13:7], value[45:14], zero pad
    input  logic [1:0]  i_s_tuser,   // op[1:0]
    // result beats
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // potential[31:0]
    output logic        o_m_tuser,   // saturated[0]
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_SIDE);
    localparam int DW    = pgs_pkg::DATA_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_UP, S_DN, S_RT, S_WAIT, S_CALC
    } t_state;

    t_state r_state;

    // configuration registers
    logic [pgs_pkg::ISZ_W-1:0]   r_isz;
    logic [pgs_pkg::SWEEP_W-1:0] r_sweeps;
    logic signed [DW-1:0]        r_scale;

    // sweep counters and operands
    logic [RW-1:0]               r_row, r_col, r_lim;
    logic [pgs_pkg::SWEEP_W-1:0] r_sweep;
    logic [DW-1:0]               r_up, r_dn, r_rt, r_left;
    logic signed [63:0]          r_prod;
    logic                        r_sat;
    logic [AW-1:0]               r_clr_addr;
    logic                        r_clr_push;
    logic                        r_rd_inside;

    // output queue
    logic [1:0]    r_cnt;
    logic [DW-1:0] r_q0_pot, r_q1_pot;
    logic          r_q0_sat, r_q1_sat;

    function automatic logic [AW-1:0] cell_addr(input logic [31:0] r, input logic [31:0] c);
        logic [31:0] t;
        t = r * 32'(GRID_SIDE) + c;
        return t[AW-1:0];
    endfunction

    // input fields
    pgs_pkg::t_op          in_op;
    logic [pgs_pkg::IDX_W-1:0] in_row, in_col;
    logic [DW-1:0]         in_value;
    logic                  in_inside;
    logic                  acc, pop;

    assign in_op     = pgs_pkg::t_op'(i_s_tuser);
    assign in_row    = i_s_tdata[6:0];
    assign in_col    = i_s_tdata[13:7];
    assign in_value  = i_s_tdata[45:14];
    assign in_inside = (32'(in_row) < 32'(GRID_SIDE)) && (32'(in_col) < 32'(GRID_SIDE));

    assign o_s_tready = (r_state == S_IDLE) && (r_cnt < 2'd2);
    assign acc        = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign pop        = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = r_q0_pot;
    assign o_m_tuser  = r_q0_sat;

    // effective interior limit
    logic [31:0]   lim_w;
    logic [RW-1:0] lim_eff;
    assign lim_w   = (32'(r_isz) > 32'(GRID_SIDE - 2)) ? 32'(GRID_SIDE - 2) : 32'(r_isz);
    assign lim_eff = lim_w[RW-1:0];

    // addresses of the current cell and its neighbors
    logic [AW-1:0] cell_a, up_a, dn_a, rt_a, in_a;
    assign cell_a = cell_addr(32'(r_row), 32'(r_col));
    assign up_a   = cell_addr(32'(r_row) - 32'd1, 32'(r_col));
    assign dn_a   = cell_addr(32'(r_row) + 32'd1, 32'(r_col));
    assign rt_a   = cell_addr(32'(r_row), 32'(r_col) + 32'd1);
    assign in_a   = cell_addr(32'(in_row), 32'(in_col));

    // neighbor masks: off-interior neighbors read as zero
    logic up_ok, dn_ok, rt_ok, lf_ok;
    assign up_ok = (r_row > RW'(1));
    assign dn_ok = (r_row < r_lim);
    assign rt_ok = (r_col < r_lim);
    assign lf_ok = (r_col > RW'(1));

    // rams
    logic          pot_we;
    logic [AW-1:0] pot_wa, pot_ra;
    logic [DW-1:0] pot_wd, pot_rd, src_rd;
    logic          src_we;

    always_comb begin
        unique case (r_state)
            S_IDLE:  pot_ra = in_a;
            S_UP:    pot_ra = up_a;
            S_DN:    pot_ra = dn_a;
            S_RT:    pot_ra = rt_a;
            default: pot_ra = cell_a;
        endcase
    end

    assign src_we = acc && (in_op == pgs_pkg::OP_LOAD) && in_inside;

    pgs_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_pot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pot_we),
        .i_wr_addr (pot_wa),
        .i_wr_data (pot_wd),
        .i_rd_addr (pot_ra),
        .o_rd_data (pot_rd)
    );

    pgs_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_src_ram (
        .i_clk     (i_clk),
        .i_wr_en   (src_we),
        .i_wr_addr (in_a),
        .i_wr_data (in_value),
        .i_rd_addr (cell_a),
        .o_rd_data (src_rd)
    );

    // cell update: (sum of neighbors - scale*source) / 4, saturated
    logic signed [33:0] nb_sum;
    logic signed [63:0] diff, v64;
    logic               sat_hi, sat_lo, cell_sat;
    logic [DW-1:0]      v;

    always_comb begin
        nb_sum = 34'(signed'(r_up)) + 34'(signed'(r_dn)) + 34'(signed'(r_rt))
               + 34'(signed'(lf_ok ? r_left : '0));
        diff   = 64'(nb_sum) - (r_prod >>> 16);
        v64    = diff >>> 2;
        sat_hi = (v64 > 64'sd2147483647);
        sat_lo = (v64 < -64'sd2147483648);
        cell_sat = sat_hi || sat_lo;
        if (sat_hi) begin
            v = 32'h7fff_ffff;
        end else if (sat_lo) begin
            v = 32'h8000_0000;
        end else begin
            v = v64[DW-1:0];
        end
    end

    logic last_col, last_row, last_sweep, run_empty;
    assign last_col   = (r_col == r_lim);
    assign last_row   = (r_row == r_lim);
    assign last_sweep = (r_sweep == r_sweeps);
    assign run_empty  = (lim_eff == '0) || (r_sweeps == '0);

    always_comb begin
        pot_we = 1'b0;
        pot_wa = cell_a;
        pot_wd = v;
        if (r_state == S_CLEAR) begin
            pot_we = 1'b1;
            pot_wa = r_clr_addr;
            pot_wd = '0;
        end else if (r_state == S_CALC) begin
            pot_we = 1'b1;
        end
    end

    // result push
    logic          push;
    logic [DW-1:0] push_pot;
    logic          push_sat;

    always_comb begin
        push     = 1'b0;
        push_pot = '0;
        push_sat = r_sat;
        unique case (r_state)
            S_IDLE: begin
                push = acc && ((in_op == pgs_pkg::OP_LOAD)
                            || ((in_op == pgs_pkg::OP_RUN) && run_empty));
            end
            S_RD: begin
                push     = 1'b1;
                push_pot = r_rd_inside ? pot_rd : '0;
            end
            S_CLEAR: begin
                push     = r_clr_push && (r_clr_addr == AW'(CELLS - 1));
                push_sat = 1'b0;
            end
            S_CALC: begin
                push     = last_col && last_row && last_sweep;
                push_sat = r_sat || cell_sat;
            end
            default: push = 1'b0;
        endcase
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_clr_push <= 1'b0;
            r_sat      <= 1'b0;
            r_cnt      <= '0;
            r_isz      <= pgs_pkg::ISZ_RST;
            r_sweeps   <= pgs_pkg::SWEEP_RST;
            r_scale    <= pgs_pkg::SCALE_RST;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (pgs_pkg::t_cfg_idx'(i_cfg_index))
                    pgs_pkg::CFG_INTERIOR: r_isz    <= i_cfg_data[pgs_pkg::ISZ_W-1:0];
                    pgs_pkg::CFG_SWEEPS:   r_sweeps <= i_cfg_data[pgs_pkg::SWEEP_W-1:0];
                    pgs_pkg::CFG_SCALE:    r_scale  <= i_cfg_data;
                    default:               ;
                endcase
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == AW'(CELLS - 1)) begin
                        r_clr_addr <= '0;
                        r_clr_push <= 1'b0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        unique case (in_op)
                            pgs_pkg::OP_LOAD: ;
                            pgs_pkg::OP_RUN: begin
                                r_lim   <= lim_eff;
                                r_row   <= RW'(1);
                                r_col   <= RW'(1);
                                r_sweep <= pgs_pkg::SWEEP_W'(1);
                                if (!run_empty) r_state <= S_UP;
                            end
                            pgs_pkg::OP_READ: begin
                                r_rd_inside <= in_inside;
                                r_state     <= S_RD;
                            end
                            pgs_pkg::OP_CLEAR: begin
                                r_sat      <= 1'b0;
                                r_clr_push <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                        endcase
                    end
                end
                S_RD:   r_state <= S_IDLE;
                S_UP:   r_state <= S_DN;
                S_DN: begin
                    r_up    <= up_ok ? pot_rd : '0;
                    r_state <= S_RT;
                end
                S_RT: begin
                    r_dn    <= dn_ok ? pot_rd : '0;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_rt    <= rt_ok ? pot_rd : '0;
                    r_prod  <= 64'(r_scale) * 64'(signed'(src_rd));
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_left <= v;
                    if (cell_sat) r_sat <= 1'b1;
                    r_state <= S_UP;
                    if (!last_col) begin
                        r_col <= r_col + RW'(1);
                    end else begin
                        r_col <= RW'(1);
                        if (!last_row) begin
                            r_row <= r_row + RW'(1);
                        end else begin
                            r_row <= RW'(1);
                            if (last_sweep) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_sweep <= r_sweep + pgs_pkg::SWEEP_W'(1);
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // output queue, two beats deep
            unique case ({push, pop})
                2'b10: begin
                    if (r_cnt == 2'd0) begin
                        r_q0_pot <= push_pot;
                        r_q0_sat <= push_sat;
                    end else begin
                        r_q1_pot <= push_pot;
                        r_q1_sat <= push_sat;
                    end
                    r_cnt <= r_cnt + 2'd1;
                end
                2'b01: begin
                    r_q0_pot <= r_q1_pot;
                    r_q0_sat <= r_q1_sat;
                    r_cnt    <= r_cnt - 2'd1;
                end
                2'b11: begin
                    if (r_cnt == 2'd1) begin
                        r_q0_pot <= push_pot;
                        r_q0_sat <= push_sat;
                    end else begin
                        r_q0_pot <= r_q1_pot;
                        r_q0_sat <= r_q1_sat;
                        r_q1_pot <= push_pot;
                        r_q1_sat <= push_sat;
                    end
                end
                default: ;
            endcase
        end
    end

    // queue never holds more than two beats
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("output queue overflow");

    // a result is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt < 2'd2) || pop) else $error("push into full queue");

    // no input beat is taken while the potential ram is being cleared
    a_no_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready) else $error("accept during clear");

endmodule
